// ===== rtl/utf8s_pkg.sv =====
package utf8s_pkg;

    localparam logic [7:0] REPLACE_CHAR  = 8'h3F;
    localparam logic [7:0] CONT_MASK     = 8'hC0;
    localparam logic [7:0] CONT_MARK     = 8'h80;
    localparam logic [7:0] LEAD2_MASK    = 8'hE0;
    localparam logic [7:0] LEAD2_MARK    = 8'hC0;
    localparam logic [7:0] LEAD3_MASK    = 8'hF0;
    localparam logic [7:0] LEAD3_MARK    = 8'hE0;
    localparam logic [7:0] LEAD4_MASK    = 8'hF8;
    localparam logic [7:0] LEAD4_MARK    = 8'hF0;
    localparam int         MAX_RESULTS   = 4;
    localparam int         HELD_DEPTH    = 3;
    localparam int         QUEUE_DEPTH_D = 8;

    // One queued command: the result beats that one input byte caused.
    typedef struct packed {
        logic [2:0]      n_bytes;
        logic [3:0][7:0] data;
        logic            eos;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Sequence length from a lead byte; zero when the byte is no lead.
    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & LEAD2_MASK) == LEAD2_MARK) begin
            len = 3'd2;
        end
        else if ((b & LEAD3_MASK) == LEAD3_MARK) begin
            len = 3'd3;
        end
        else if ((b & LEAD4_MASK) == LEAD4_MARK) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

// ===== rtl/utf8s_front.sv =====
module utf8s_front
    import utf8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output logic       push,
    output cmd_t       cmd
);

    logic [7:0] held_reg [HELD_DEPTH];
    logic [7:0] held_next [HELD_DEPTH];
    logic [1:0] hc_reg, hc_next;
    logic [2:0] exp_reg, exp_next;
    logic       is_cont;
    logic       fresh;
    logic [2:0] len;
    logic [2:0] n;
    logic [3:0][7:0] data;

    always_comb
    begin
        is_cont = (data_byte & CONT_MASK) == CONT_MARK;
        len     = seq_length(data_byte);
        fresh   = 1'b1;
        n       = 3'd0;
        data    = {4{REPLACE_CHAR}};
        hc_next = hc_reg;
        exp_next = exp_reg;
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            held_next[i] = held_reg[i];
        end

        if (hc_reg != 2'd0)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if ({1'b0, hc_reg} + 3'd1 == exp_reg)
                begin
                    // sequence complete: release it whole
                    for (int i = 0; i < HELD_DEPTH; i++)
                    begin
                        if (2'(i) < hc_reg)
                        begin
                            data[i] = held_reg[i];
                        end
                    end
                    data[hc_reg] = data_byte;
                    n        = {1'b0, hc_reg} + 3'd1;
                    hc_next  = 2'd0;
                    exp_next = 3'd0;
                end
                else if (end_of_string || hc_reg == 2'd3)
                begin
                    n        = {1'b0, hc_reg} + 3'd1;
                    hc_next  = 2'd0;
                    exp_next = 3'd0;
                end
                else
                begin
                    held_next[hc_reg] = data_byte;
                    hc_next = hc_reg + 2'd1;
                end
            end
            else
            begin
                // early break: replace what is held, then start afresh
                n        = {1'b0, hc_reg};
                hc_next  = 2'd0;
                exp_next = 3'd0;
            end
        end

        if (fresh)
        begin
            if (data_byte < CONT_MARK)
            begin
                data[n[1:0]] = data_byte;
                n = n + 3'd1;
            end
            else if (len == 3'd0 || end_of_string)
            begin
                data[n[1:0]] = REPLACE_CHAR;
                n = n + 3'd1;
            end
            else
            begin
                held_next[0] = data_byte;
                hc_next  = 2'd1;
                exp_next = len;
            end
        end
    end

    assign push        = accept && (n != 3'd0);
    assign cmd.n_bytes = n;
    assign cmd.data    = data;
    assign cmd.eos     = end_of_string;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg  <= 2'd0;
            exp_reg <= 3'd0;
        end
        else if (accept)
        begin
            hc_reg  <= hc_next;
            exp_reg <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < HELD_DEPTH; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_string |=> hc_reg == 2'd0)
        else $error("hold not cleared after end of string");

    a_hold_len: assert property (@(posedge clk) disable iff (!rst_n)
        (hc_reg == 2'd0) == (exp_reg == 3'd0))
        else $error("held count and expected length disagree");

endmodule

// ===== rtl/utf8s_fifo.sv =====
module utf8s_fifo
    import utf8s_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      wr_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = cnt_reg == CW'(QUEUE_DEPTH);
    assign status.empty = cnt_reg == CW'(0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");

endmodule

// ===== rtl/utf8s_back.sv =====
module utf8s_back
    import utf8s_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  q_status_t  status,
    output logic       pop,
    output logic       dn_valid,
    input  logic       dn_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic [1:0] idx_reg, idx_next;
    logic       advance;
    logic       is_last;

    always_comb
    begin
        advance    = !valid_reg || !dn_stall;
        is_last    = ({1'b0, idx_reg} + 3'd1) == head.n_bytes;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (advance)
        begin
            valid_next = !status.empty;
            if (!status.empty)
            begin
                byte_next = head.data[idx_reg];
                last_next = is_last;
                done_next = is_last && head.eos;
                pop       = is_last;
                idx_next  = is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign dn_valid    = valid_reg;
    assign out_byte    = byte_reg;
    assign run_last    = last_reg;
    assign string_done = done_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && done_reg |-> last_reg)
        else $error("string end flagged on a beat that is not the last of its item");

endmodule

// ===== rtl/utf8_sanitize_replace_top.sv =====
// UTF-8 cleaner: one raw byte in per beat, one cleaned byte out per beat.
// Upstream channel: up_valid / up_stall carry data_byte and end_of_string.
// Downstream channel: dn_valid / dn_stall carry out_byte, run_last and
// string_done. A beat moves on an edge where valid is high and stall low.
// ASCII passes through; a well formed multi-byte sequence is held and then
// released whole; broken sequences, stray continuations and F8..FF come out
// as '?'. Each input byte gives one output byte in total, but one input beat
// may give zero to four output beats; run_last marks the last of them and
// string_done the final beat of a string.
// With an idle queue, the first result beat of an accepted item passes through the
// queue and then the output register. Throughput: one input beat per cycle while the
// queue is not full, and one output beat per cycle while the queue holds a command and
// dn_stall is low. The command queue between the classifier and the byte emitter
// (QUEUE_DEPTH commands) never fills while dn_stall stays low; up_stall rises only while it is full.
// Reset clears the hold state, the queue and the output register.
// While dn_stall is high the output beat holds and the queue fills; input
// keeps flowing until the queue is full.
module utf8_sanitize_replace_top
    import utf8s_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output logic       dn_valid,
    input  logic       dn_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_done
);

    logic      accept;
    logic      push;
    logic      pop;
    cmd_t      wr_cmd;
    cmd_t      head;
    q_status_t status;

    // Stall upstream only on a full queue; this is registered state.
    assign up_stall = status.full;
    assign accept   = up_valid && !up_stall;

    // Classify each byte and build its result command.
    utf8s_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .push          (push),
        .cmd           (wr_cmd)
    );

    // Decouple the classifier from the emitter.
    utf8s_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    // Emit the head command one byte per beat.
    utf8s_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .status      (status),
        .pop         (pop),
        .dn_valid    (dn_valid),
        .dn_stall    (dn_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

// ===== verif/tb.sv =====
module tb
    import utf8s_pkg::*;
();

    // Run length and safety net
    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 16;

    // Cleaner model plus the queue of result beats still owed by the block
    class utf8_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
            logic       done;
        } beat_t;

        logic [7:0]  lead_store [3];
        int unsigned lead_count;
        int unsigned lead_len;
        beat_t       owed_q [$];
        int          errors;
        int          n_in;
        int          n_out;
        int          n_repl;
        int          n_strings;

        function new();
            lead_count = 0;
            lead_len   = 0;
            errors     = 0;
            n_in       = 0;
            n_out      = 0;
            n_repl     = 0;
            n_strings  = 0;
            foreach (lead_store[k])
                lead_store[k] = 8'h00;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function int unsigned lead_class(logic [7:0] b);
            int unsigned len;
            casez (b)
                8'b110?????: len = 2;
                8'b1110????: len = 3;
                8'b11110???: len = 4;
                default:     len = 0;
            endcase
            return len;
        endfunction

        // Work out the result beats of one accepted input beat
        function void note_input(logic [7:0] b, logic eos);
            logic [7:0]  run [$];
            beat_t       beat;
            bit          restart;
            int unsigned i;
            restart = 1'b1;
            n_in++;
            if (eos)
                n_strings++;
            if (lead_count > 0)
            begin
                if ((b & CONT_MASK) == CONT_MARK)
                begin
                    restart = 1'b0;
                    if (lead_count + 1 == lead_len)
                    begin
                        for (i = 0; i < lead_count; i++)
                            run.insert(run.size(), lead_store[i]);
                        run.insert(run.size(), b);
                        lead_count = 0;
                        lead_len   = 0;
                    end
                    else if (eos || lead_count >= 3)
                    begin
                        for (i = 0; i <= lead_count; i++)
                            run.insert(run.size(), REPLACE_CHAR);
                        n_repl += lead_count + 1;
                        lead_count = 0;
                        lead_len   = 0;
                    end
                    else
                    begin
                        lead_store[lead_count] = b;
                        lead_count++;
                    end
                end
                else
                begin
                    for (i = 0; i < lead_count; i++)
                        run.insert(run.size(), REPLACE_CHAR);
                    n_repl += lead_count;
                    lead_count = 0;
                    lead_len   = 0;
                end
            end
            if (restart)
            begin
                if (b < 8'h80)
                begin
                    run.insert(run.size(), b);
                end
                else if (lead_class(b) == 0 || eos)
                begin
                    run.insert(run.size(), REPLACE_CHAR);
                    n_repl++;
                end
                else
                begin
                    lead_store[0] = b;
                    lead_count    = 1;
                    lead_len      = lead_class(b);
                end
            end
            for (i = 0; i < run.size(); i++)
            begin
                beat.data = run[i];
                beat.last = (i == run.size() - 1);
                beat.done = (i == run.size() - 1) && eos;
                owed_q.insert(owed_q.size(), beat);
            end
        endfunction

        // Compare one accepted result beat with the oldest one owed
        function void check_result(logic [7:0] data, logic last, logic done);
            beat_t want;
            n_out++;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result beat: out_byte %h run_last %b string_done %b",
                       data, last, done);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (data !== want.data)
            begin
                $error("out_byte: expected %h, actual %h", want.data, data);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("run_last: expected %b, actual %b", want.last, last);
                errors++;
            end
            if (done !== want.done)
            begin
                $error("string_done: expected %b, actual %b", want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       up_valid      = 1'b0;
    logic       up_stall;
    logic [7:0] data_byte     = 8'h00;
    logic       end_of_string = 1'b0;
    logic       dn_valid;
    logic       dn_stall      = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;

    utf8_scoreboard sb = new();

    int          cycle_count = 0;
    int          burst_left  = 0;
    int          n_sent      = 0;
    int unsigned stall_mode  = 0;
    logic [7:0]  str_buf [$];

    utf8_sanitize_replace_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (up_valid),
        .up_stall      (up_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .dn_valid      (dn_valid),
        .dn_stall      (dn_stall),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .string_done   (string_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Sample both channels on the rising edge, before the block updates.
    // Note the input beat first: its results cannot appear on the same edge.
    always @(posedge clk)
    begin
        if (rst_n && up_valid && !up_stall)
            sb.note_input(data_byte, end_of_string);
        if (rst_n && dn_valid && !dn_stall)
            sb.check_result(out_byte, run_last, string_done);
    end

    // Receiver back-pressure: switch between a few stall styles every so often,
    // including a style that never stalls at all.
    always @(negedge clk)
    begin
        if (cycle_count % 97 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       dn_stall <= 1'b0;
            1:       dn_stall <= ($urandom_range(0, 99) < 25);
            2:       dn_stall <= ($urandom_range(0, 99) < 70);
            default: dn_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    // Hang guard
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive one input beat and hold it until the block takes it. Between
    // bursts, drop valid for a random gap; long bursts give stretches of
    // back-to-back beats.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            repeat (gap)
            begin
                @(negedge clk);
                up_valid <= 1'b0;
            end
        end
        @(negedge clk);
        up_valid      <= 1'b1;
        data_byte     <= b;
        end_of_string <= eos;
        do
            @(posedge clk);
        while (up_stall);
        burst_left--;
        n_sent++;
    endtask

    // Send the buffered string, flagging its last byte, then empty the buffer
    task automatic send_string();
        int i;
        for (i = 0; i < str_buf.size(); i++)
            send_byte(str_buf[i], i == str_buf.size() - 1);
        str_buf.delete();
    endtask

    // Hold the sender off until every owed result beat has come back
    task automatic wait_drained();
        @(negedge clk);
        up_valid   <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic load(input logic [7:0] b);
        str_buf.insert(str_buf.size(), b);
    endtask

    // Append one piece of text to the string buffer: mostly well-formed
    // characters, with truncated sequences, stray continuations and junk mixed in.
    task automatic add_token();
        int pick;
        int n;
        int k;
        pick = $urandom_range(0, 99);
        if (pick < 38)
        begin
            load(8'($urandom_range(0, 127)));
        end
        else if (pick < 53)
        begin
            load(8'hC0 | 8'($urandom_range(0, 31)));
            load(cont_byte());
        end
        else if (pick < 65)
        begin
            load(8'hE0 | 8'($urandom_range(0, 15)));
            repeat (2) load(cont_byte());
        end
        else if (pick < 75)
        begin
            load(8'hF0 | 8'($urandom_range(0, 7)));
            repeat (3) load(cont_byte());
        end
        else if (pick < 85)
        begin
            // lead whose sequence is cut short
            n = $urandom_range(2, 4);
            case (n)
                2:       load(8'hC0 | 8'($urandom_range(0, 31)));
                3:       load(8'hE0 | 8'($urandom_range(0, 15)));
                default: load(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            k = $urandom_range(0, n - 2);
            repeat (k) load(cont_byte());
        end
        else if (pick < 90)
        begin
            load(cont_byte());
        end
        else if (pick < 95)
        begin
            load(8'hF8 | 8'($urandom_range(0, 7)));
        end
        else
        begin
            load(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int  tokens;
        bit  paused;
        paused = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ASCII extremes, string closed on a plain byte
        load(8'h00); load(8'h7F); load(8'h41);
        send_string();
        // complete two-, three- and four-byte characters, the last one closing
        // the string on its final continuation
        load(8'hC3); load(8'hA9);
        load(8'hE2); load(8'h82); load(8'hAC);
        load(8'hF0); load(8'h9F); load(8'h98); load(8'h80);
        send_string();
        // stray continuation, invalid bytes, lead broken by ASCII, lead broken
        // by a fresh lead which then completes
        load(8'h80); load(8'hF8); load(8'hFF);
        load(8'hC3); load(8'h41);
        load(8'hE2); load(8'h82); load(8'hC3); load(8'hA9);
        send_string();
        // string ends on a continuation that leaves the sequence unfinished
        load(8'hE2); load(8'h82);
        send_string();
        // lead byte that is itself the end of a string
        load(8'hC3);
        send_string();

        wait_drained();

        // Random strings; once, midway, let the block drain completely
        while (n_sent < RANDOM_ITEMS)
        begin
            tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                 : $urandom_range(1, 8);
            repeat (tokens) add_token();
            send_string();
            if (!paused && n_sent >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        @(negedge clk);
        up_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);

        $display("Run covered %0d input bytes in %0d strings and %0d result beats,",
                 sb.n_in, sb.n_strings, sb.n_out);
        $display("of which %0d were replacement characters.", sb.n_repl);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
